/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(prop)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, prop)
`endif
`endif

/* rtl/lsrc_pkg.sv */
package lsrc_pkg;

   localparam int CW   = 33;            // internal coordinate width
   localparam int DFW  = CW + 1;        // coordinate difference width
   localparam int PW   = 2 * DFW;       // product width
   localparam int QW   = 36;            // quotient bits produced
   localparam int RW   = DFW + 1;       // partial remainder width
   localparam int BPS  = 3;             // quotient bits per divider stage
   localparam int DSTG = QW / BPS;      // divider stages
   localparam int NS   = 3 + DSTG + 1;  // stages per clipping phase
   localparam int NPH  = 8;
   localparam int LATENCY = 1 + NPH * NS + 1;

   typedef enum logic [1:0] {
      REG_BOX_LEFT   = 2'd0,
      REG_BOX_TOP    = 2'd1,
      REG_BOX_RIGHT  = 2'd2,
      REG_BOX_BOTTOM = 2'd3
   } reg_idx_type;

   // coordinate selector: bit 1 picks the endpoint, bit 0 picks y
   typedef enum logic [1:0] {
      SEL_X1 = 2'd0,
      SEL_Y1 = 2'd1,
      SEL_X2 = 2'd2,
      SEL_Y2 = 2'd3
   } coord_sel_type;

   typedef logic signed [CW-1:0] coord_type;

   typedef struct packed {
      logic      vis;
      coord_type x1;
      coord_type y1;
      coord_type x2;
      coord_type y2;
      coord_type lo_x;
      coord_type lo_y;
      coord_type hi_x;
      coord_type hi_y;
   } seg_type;

   typedef struct packed {
      logic                  mv;
      logic                  dok;
      logic                  neg;
      logic signed [DFW-1:0] dn;
      logic signed [DFW-1:0] dd;
      logic signed [DFW-1:0] dof;
      logic signed [PW-1:0]  prod;
      logic [DFW-1:0]        dabs;
      logic [RW-1:0]         rem;
      logic [QW-1:0]         low;
   } work_type;

endpackage

/* rtl/lsrc_phase.sv */
module lsrc_phase import lsrc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic [2:0] phase_idx,
   input  logic     in_valid,
   input  seg_type  in_seg,
   output logic     out_valid,
   output seg_type  out_seg
);

   function automatic coord_type get_c(seg_type s, logic [1:0] sel);
      coord_type v;
      case (sel)
         SEL_X1:  v = s.x1;
         SEL_Y1:  v = s.y1;
         SEL_X2:  v = s.x2;
         SEL_Y2:  v = s.y2;
         default: v = s.x1;
      endcase
      return v;
   endfunction

   function automatic seg_type put_c(seg_type s, logic [1:0] sel, coord_type v);
      seg_type r;
      r = s;
      case (sel)
         SEL_X1:  r.x1 = v;
         SEL_Y1:  r.y1 = v;
         SEL_X2:  r.x2 = v;
         SEL_Y2:  r.y2 = v;
         default: r.x1 = v;
      endcase
      return r;
   endfunction

   logic    axis, side, second;
   logic [1:0] sel_a, sel_ao, sel_b, sel_bo;

   assign axis   = phase_idx[2];
   assign side   = phase_idx[1];
   assign second = phase_idx[0];
   assign sel_a  = {second, axis};
   assign sel_ao = {second, ~axis};
   assign sel_b  = {~second, axis};
   assign sel_bo = {~second, ~axis};

   logic     vld_ff [NS];
   seg_type  seg_ff [NS];
   work_type wrk_ff [NS];
   logic     vld_in [NS];
   seg_type  seg_in [NS];
   work_type wrk_in [NS];

   genvar s;
   generate
      for (s = 0; s < NS; s++) begin : g_stage
         if (s == 0) begin : g_decide
            always_comb begin
               coord_type a, ao, b, bo, edg;
               logic ba, bb;
               a   = get_c(in_seg, sel_a);
               ao  = get_c(in_seg, sel_ao);
               b   = get_c(in_seg, sel_b);
               bo  = get_c(in_seg, sel_bo);
               edg = side ? (axis ? in_seg.hi_y : in_seg.hi_x)
                          : (axis ? in_seg.lo_y : in_seg.lo_x);
               ba  = side ? (a > edg) : (a < edg);
               bb  = side ? (b > edg) : (b < edg);
               vld_in[s] = in_valid;
               seg_in[s] = in_seg;
               wrk_in[s] = '0;
               wrk_in[s].dn  = DFW'(edg) - DFW'(a);
               wrk_in[s].dd  = DFW'(b) - DFW'(a);
               wrk_in[s].dof = DFW'(bo) - DFW'(ao);
               if (in_seg.vis && ba) begin
                  // on the first pass of an edge, reject when both ends lie beyond it
                  if (!second && bb) begin
                     seg_in[s].vis = 1'b0;
                  end else begin
                     wrk_in[s].mv = 1'b1;
                     seg_in[s]    = put_c(in_seg, sel_a, edg);
                  end
               end
            end
         end else if (s == 1) begin : g_mul
            always_comb begin
               vld_in[s] = vld_ff[s-1];
               seg_in[s] = seg_ff[s-1];
               wrk_in[s] = wrk_ff[s-1];
               wrk_in[s].prod = PW'(wrk_ff[s-1].dn) * PW'(wrk_ff[s-1].dof);
               wrk_in[s].dabs = wrk_ff[s-1].dd[DFW-1] ? DFW'(-wrk_ff[s-1].dd)
                                                      : DFW'(wrk_ff[s-1].dd);
               wrk_in[s].dok  = (wrk_ff[s-1].dd != '0);
               wrk_in[s].neg  = wrk_ff[s-1].dn[DFW-1] ^ wrk_ff[s-1].dof[DFW-1]
                                ^ wrk_ff[s-1].dd[DFW-1];
            end
         end else if (s == 2) begin : g_abs
            always_comb begin
               logic [PW-1:0] nabs;
               nabs = wrk_ff[s-1].prod[PW-1] ? PW'(-wrk_ff[s-1].prod)
                                             : PW'(wrk_ff[s-1].prod);
               vld_in[s] = vld_ff[s-1];
               seg_in[s] = seg_ff[s-1];
               wrk_in[s] = wrk_ff[s-1];
               wrk_in[s].rem = RW'(nabs[PW-1:QW]);
               wrk_in[s].low = nabs[QW-1:0];
            end
         end else if (s < NS - 1) begin : g_div
            always_comb begin
               logic [RW-1:0] r;
               logic [QW-1:0] q;
               logic [RW-1:0] sh;
               r = wrk_ff[s-1].rem;
               q = wrk_ff[s-1].low;
               for (int k = 0; k < BPS; k++) begin
                  sh = {r[RW-2:0], q[QW-1]};
                  q  = {q[QW-2:0], 1'b0};
                  if (sh >= RW'(wrk_ff[s-1].dabs)) begin
                     r    = sh - RW'(wrk_ff[s-1].dabs);
                     q[0] = 1'b1;
                  end else begin
                     r = sh;
                  end
               end
               vld_in[s] = vld_ff[s-1];
               seg_in[s] = seg_ff[s-1];
               wrk_in[s] = wrk_ff[s-1];
               wrk_in[s].rem = r;
               wrk_in[s].low = q;
            end
         end else begin : g_fix
            always_comb begin
               coord_type ao, q;
               ao = get_c(seg_ff[s-1], sel_ao);
               q  = CW'(wrk_ff[s-1].low);
               vld_in[s] = vld_ff[s-1];
               seg_in[s] = seg_ff[s-1];
               wrk_in[s] = wrk_ff[s-1];
               if (wrk_ff[s-1].mv && wrk_ff[s-1].dok) begin
                  seg_in[s] = put_c(seg_ff[s-1], sel_ao,
                                    wrk_ff[s-1].neg ? ao - q : ao + q);
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[s] <= 1'b0;
            end else begin
               vld_ff[s] <= vld_in[s];
            end
            seg_ff[s] <= seg_in[s];
            wrk_ff[s] <= wrk_in[s];
         end
      end
   endgenerate

   assign out_valid = vld_ff[NS-1];
   assign out_seg   = seg_ff[NS-1];

endmodule

/* rtl/line_segment_rect_clipper.sv */
// Channel   Ports                                  Direction  Handshake
// request   start, busy, req_*                     in         start & !busy
// result    rsp_valid, rsp_*                       out        one-cycle strobe
// config    csr_we, csr_index, csr_wdata           in         write on csr_we
//
// A request can enter every cycle while busy is low; its result passes the input
// register, the eight clipping phases and the output register. Each phase is a 16-stage slice: decide, multiply,
// magnitude, twelve 3-bit restoring divide steps, and a final correction.
// Reset clears valid bits and loads the default rectangle; busy is high only
// during reset. The result side has no stall, so the pipeline always advances.
`include "assert_macros.svh"
module line_segment_rect_clipper import lsrc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [30:0] req_start_x,
   input  logic signed [30:0] req_start_y,
   input  logic signed [30:0] req_end_x,
   input  logic signed [30:0] req_end_y,
   input  logic [29:0]        req_edge_margin,
   output logic               rsp_valid,
   output logic               rsp_visible,
   output logic signed [31:0] rsp_clip_start_x,
   output logic signed [31:0] rsp_clip_start_y,
   output logic signed [31:0] rsp_clip_end_x,
   output logic signed [31:0] rsp_clip_end_y,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [30:0]        csr_wdata
);

   logic [30:0] box_left_ff, box_top_ff, box_right_ff, box_bottom_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_left_ff   <= '0;
         box_top_ff    <= '0;
         box_right_ff  <= 31'h3FFF_FFFF;
         box_bottom_ff <= 31'h3FFF_FFFF;
      end else if (csr_we) begin
         case (reg_idx_type'(csr_index))
            REG_BOX_LEFT:   box_left_ff   <= csr_wdata;
            REG_BOX_TOP:    box_top_ff    <= csr_wdata;
            REG_BOX_RIGHT:  box_right_ff  <= csr_wdata;
            REG_BOX_BOTTOM: box_bottom_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   function automatic coord_type sx(logic [30:0] v);
      return {{(CW-31){v[30]}}, v};
   endfunction

   logic    accept;
   logic    in_vld_ff;
   seg_type in_seg_ff, in_seg_in;
   coord_type m;

   assign busy   = reset;
   assign accept = start & ~busy;
   assign m      = {{(CW-30){1'b0}}, req_edge_margin};

   always_comb begin
      in_seg_in.vis  = 1'b1;
      in_seg_in.x1   = sx(req_start_x);
      in_seg_in.y1   = sx(req_start_y);
      in_seg_in.x2   = sx(req_end_x);
      in_seg_in.y2   = sx(req_end_y);
      in_seg_in.lo_x = sx(box_left_ff) - m;
      in_seg_in.lo_y = sx(box_top_ff) - m;
      in_seg_in.hi_x = sx(box_right_ff) + m;
      in_seg_in.hi_y = sx(box_bottom_ff) + m;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= accept;
      end
      in_seg_ff <= in_seg_in;
   end

   logic    ph_vld [NPH+1];
   seg_type ph_seg [NPH+1];

   assign ph_vld[0] = in_vld_ff;
   assign ph_seg[0] = in_seg_ff;

   genvar p;
   generate
      for (p = 0; p < NPH; p++) begin : g_phase
         lsrc_phase u_phase (
            .clock     (clock),
            .reset     (reset),
            .phase_idx (3'(p)),
            .in_valid  (ph_vld[p]),
            .in_seg    (ph_seg[p]),
            .out_valid (ph_vld[p+1]),
            .out_seg   (ph_seg[p+1])
         );
      end
   endgenerate

   logic        out_vld_ff, out_vis_ff;
   logic [31:0] out_x1_ff, out_y1_ff, out_x2_ff, out_y2_ff;
   seg_type     fin;

   assign fin = ph_seg[NPH];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= ph_vld[NPH];
      end
      out_vis_ff <= fin.vis;
      // drop coordinates of a rejected segment
      out_x1_ff  <= fin.vis ? fin.x1[31:0] : '0;
      out_y1_ff  <= fin.vis ? fin.y1[31:0] : '0;
      out_x2_ff  <= fin.vis ? fin.x2[31:0] : '0;
      out_y2_ff  <= fin.vis ? fin.y2[31:0] : '0;
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_visible      = out_vis_ff;
   assign rsp_clip_start_x = out_x1_ff;
   assign rsp_clip_start_y = out_y1_ff;
   assign rsp_clip_end_x   = out_x2_ff;
   assign rsp_clip_end_y   = out_y2_ff;

   `ASSERT_ALWAYS(a_rejected_zero, clock, reset,
      (rsp_valid && !rsp_visible) |-> (rsp_clip_start_x == '0 && rsp_clip_start_y == '0
         && rsp_clip_end_x == '0 && rsp_clip_end_y == '0))
   `ASSERT_ALWAYS(a_latency, clock, reset,
      rsp_valid == $past(accept, LATENCY))
   `ASSERT_NEVER(a_first_stage_vis, clock, reset,
      in_vld_ff && !in_seg_ff.vis)

endmodule
